### rtl/u8sd_pkg.sv
package u8sd_pkg;

  localparam int unsigned CP_W = 21;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_CHAR    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_END     = 2'd2;

  // one queue entry: invalid marks for a broken sequence, then an optional tail result
  typedef struct packed {
    logic [1:0]      flush_cnt;
    logic            has_tail;
    logic [1:0]      tail_status;
    logic [CP_W-1:0] tail_cp;
  } cmd_t;

endpackage

### rtl/u8sd_front.sv
module u8sd_front
  import u8sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [1:0]      bytes_needed_r, bytes_needed_nxt;
  logic [1:0]      bytes_seen_r, bytes_seen_nxt;
  logic [CP_W-1:0] partial_value_r, partial_value_nxt;
  logic            accept;
  logic            is_cont;
  logic [1:0]      seen_inc;
  logic [CP_W-1:0] shifted;

  assign accept   = in_valid && !q_full;
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign seen_inc = bytes_seen_r + 2'd1;
  assign shifted  = {partial_value_r[CP_W-7:0], in_byte[5:0]};

  always_comb begin
    bytes_needed_nxt     = bytes_needed_r;
    bytes_seen_nxt       = bytes_seen_r;
    partial_value_nxt    = partial_value_r;
    push_cmd.flush_cnt   = 2'd0;
    push_cmd.has_tail    = 1'b0;
    push_cmd.tail_status = ST_CHAR;
    push_cmd.tail_cp     = '0;

    if (bytes_needed_r != 2'd0 && is_cont) begin
      partial_value_nxt = shifted;
      bytes_seen_nxt    = seen_inc;
      if (seen_inc >= bytes_needed_r) begin
        push_cmd.has_tail    = 1'b1;
        push_cmd.tail_status = ST_CHAR;
        push_cmd.tail_cp     = shifted;
        bytes_needed_nxt     = 2'd0;
        bytes_seen_nxt       = 2'd0;
        partial_value_nxt    = '0;
      end
    end else begin
      // broken sequence: lead plus buffered continuations are flushed as invalid
      if (bytes_needed_r != 2'd0) begin
        push_cmd.flush_cnt = seen_inc;
      end
      bytes_needed_nxt  = 2'd0;
      bytes_seen_nxt    = 2'd0;
      partial_value_nxt = '0;
      priority if (in_byte == 8'h00) begin
        push_cmd.has_tail    = 1'b1;
        push_cmd.tail_status = ST_END;
      end else if (!in_byte[7]) begin
        push_cmd.has_tail    = 1'b1;
        push_cmd.tail_status = ST_CHAR;
        push_cmd.tail_cp     = CP_W'(in_byte[6:0]);
      end else if (in_byte[7:5] == 3'b110) begin
        bytes_needed_nxt  = 2'd1;
        partial_value_nxt = CP_W'(in_byte[4:0]);
      end else if (in_byte[7:4] == 4'b1110) begin
        bytes_needed_nxt  = 2'd2;
        partial_value_nxt = CP_W'(in_byte[3:0]);
      end else if (in_byte[7:3] == 5'b11110) begin
        bytes_needed_nxt  = 2'd3;
        partial_value_nxt = CP_W'(in_byte[2:0]);
      end else begin
        push_cmd.has_tail    = 1'b1;
        push_cmd.tail_status = ST_INVALID;
      end
    end
  end

  assign push = accept && (push_cmd.has_tail || push_cmd.flush_cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_needed_r  <= 2'd0;
      bytes_seen_r    <= 2'd0;
      partial_value_r <= '0;
    end else if (accept) begin
      bytes_needed_r  <= bytes_needed_nxt;
      bytes_seen_r    <= bytes_seen_nxt;
      partial_value_r <= partial_value_nxt;
    end
  end

endmodule

### rtl/u8sd_queue.sv
module u8sd_queue
  import u8sd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic not_empty,
  output logic full
);

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_cmd  = entries_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/u8sd_back.sv
module u8sd_back
  import u8sd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cmd_t            head_cmd,
  input  logic            not_empty,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [CP_W-1:0] out_code_point,
  output logic [1:0]      out_status,
  output logic            out_last_of_run
);

  logic            out_valid_r;
  logic [CP_W-1:0] code_point_r;
  logic [1:0]      status_r;
  logic            last_r;
  logic [1:0]      idx_r;
  logic            load;
  logic            in_flush;
  logic            last_flush;
  logic            res_last;
  logic [CP_W-1:0] res_cp;
  logic [1:0]      res_status;

  assign load       = not_empty && (!out_valid_r || !out_stall);
  assign in_flush   = (idx_r < head_cmd.flush_cnt);
  assign last_flush = (idx_r == head_cmd.flush_cnt - 2'd1);

  always_comb begin
    if (in_flush) begin
      res_cp     = '0;
      res_status = ST_INVALID;
      res_last   = last_flush && !head_cmd.has_tail;
    end else begin
      res_cp     = head_cmd.tail_cp;
      res_status = head_cmd.tail_status;
      res_last   = 1'b1;
    end
  end

  assign pop = load && res_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= res_last ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point_r <= res_cp;
      status_r     <= res_status;
      last_r       <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = code_point_r;
  assign out_status      = status_r;
  assign out_last_of_run = last_r;

endmodule

### rtl/utf8_stream_decoder.sv
// utf8_stream_decoder: turns a stream of UTF-8 bytes into code points.
// input channel: in_valid/in_stall carry one byte (in_byte) per request; a zero
// byte ends a string and clears any open sequence.
// result channel: out_valid/out_stall carry out_code_point, out_status (char,
// invalid, end) and out_last_of_run, set on the final result caused by a byte.
// the front decoder writes an accepted byte's command into the queue; the back end
// then registers its results. lead and middle bytes of a sequence give no result.
// throughput: one byte per cycle while each byte gives at most one result; a byte
// that breaks a sequence gives up to four results, issued one per cycle by the
// back end. a four-entry command queue between the two absorbs these bursts and
// in_stall rises only when that queue is full.
// when out_stall is high the current result holds and the queue keeps filling.
// reset (rst_n low, synchronous) returns the decoder to idle, empties the queue
// and drops out_valid.
module utf8_stream_decoder
  import u8sd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_code_point,
  output logic [1:0]      out_status,
  output logic            out_last_of_run
);

  logic push, pop, not_empty, full;
  cmd_t push_cmd, head_cmd;

  assign in_stall = full;

  u8sd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .q_full   (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  u8sd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (not_empty),
    .full      (full)
  );

  u8sd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_cmd        (head_cmd),
    .not_empty       (not_empty),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_code_point  (out_code_point),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

endmodule
